// ===== src/ttce_pkg.sv =====
// ============================================================================
// ttce_pkg
// Shared constants, configuration types and the quarter-wave cosine tables
// for the time-to-collision emergency brake.
// ============================================================================
package ttce_pkg;

    // Item kinds carried in tuser.
    localparam logic [1:0] KIND_SPEED = 2'd0;
    localparam logic [1:0] KIND_BEAM  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TTC_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_SCANS   = 3'd5;
    localparam int CFG_DATA_W = 16;

    // Field widths.
    localparam int THR_W    = 14;
    localparam int MINSPD_W = 15;
    localparam int ANGLE_W  = 16;
    localparam int HOLD_W   = 16;
    localparam int CNT_W    = 8;
    localparam int SPEED_W  = 16;
    localparam int RANGE_W  = 16;
    localparam int REACH_W  = THR_W + SPEED_W - 1;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]    RST_TTC_THRESHOLD = 14'd500;
    localparam logic [MINSPD_W-1:0] RST_MIN_SPEED     = 15'd100;
    localparam logic [ANGLE_W-1:0]  RST_ANGLE_START   = 16'hA000;
    localparam logic [ANGLE_W-1:0]  RST_ANGLE_STEP    = 16'd46;
    localparam logic [HOLD_W-1:0]   RST_MIN_HOLD      = 16'd1000;
    localparam logic [CNT_W-1:0]    RST_CLEAR_SCANS   = 8'd10;

    typedef struct packed {
        logic [THR_W-1:0]    ttc_threshold_ms;
        logic [MINSPD_W-1:0] min_speed_mm_s;
        logic [ANGLE_W-1:0]  angle_start;
        logic [ANGLE_W-1:0]  angle_step;
        logic [HOLD_W-1:0]   min_hold_ms;
        logic [CNT_W-1:0]    clear_scans;
    } cfg_t;

    // Events from the item stage to the brake latch.
    typedef struct packed {
        logic scan_end;
        logic tick;
        logic danger;
        logic speed_ok;
    } brake_evt_t;

    typedef struct packed {
        logic             latched;
        logic             brake_next;
        logic [CNT_W-1:0] clear_next;
    } brake_stat_t;

    // Cosine table geometry. Depth is a power of two.
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int COS_FRAC_BITS   = 15;
    localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
    localparam int QTR_IDX_W       = COS_IDX_W - 2;
    localparam int QTR_DEPTH       = COS_TABLE_DEPTH / 4;
    localparam int COS_W           = COS_FRAC_BITS + 1;

    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam int     ROUND_SH    = 30 - COS_FRAC_BITS;

    // Taylor divisors n*(n+1) for the cosine and sine series.
    localparam longint COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};
    localparam longint SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef logic [COS_W-1:0] cos_quarter_t [QTR_DEPTH];

    // Builds one positive quarter of the table: the cosine series for the
    // first quadrant, or the sine series that the fourth quadrant uses.
    function automatic cos_quarter_t build_cos_quarter(input bit use_sin);
        cos_quarter_t tab;
        longint       r;
        longint       x;
        longint       x2;
        longint       term;
        longint       sum;
        longint       mag;
        for (int k = 0; k < QTR_DEPTH; k++) begin
            r  = (longint'(k) * ONE_Q30) / QTR_DEPTH;
            x  = (r * PI_HALF_Q30) >>> 30;
            x2 = (x * x) >>> 30;
            term = use_sin ? x : ONE_Q30;
            sum  = term;
            for (int t = 0; t < 7; t++) begin
                if (use_sin) begin
                    term = -((term * x2) / ONE_Q30) / SIN_DIV[t];
                end
                else begin
                    term = -((term * x2) / ONE_Q30) / COS_DIV[t];
                end
                sum = sum + term;
            end
            if (sum <= 0) begin
                mag = 0;
            end
            else begin
                mag = (sum + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
                if (mag > (64'sd1 <<< COS_FRAC_BITS)) begin
                    mag = 64'sd1 <<< COS_FRAC_BITS;
                end
            end
            tab[k] = mag[COS_W-1:0];
        end
        return tab;
    endfunction

    localparam cos_quarter_t COS_Q_FIRST  = build_cos_quarter(1'b0);
    localparam cos_quarter_t COS_Q_FOURTH = build_cos_quarter(1'b1);

endpackage

// ===== src/ttc_emergency_brake.sv =====
// ============================================================================
// ttc_emergency_brake
// Time-to-collision emergency brake over a streamed lidar scan.
// ============================================================================
// The block takes one transaction per clock on the slave side: a speed
// update, a beam sample or a millisecond tick, selected by s_tuser. Each
// item passes through an input register and is finished by one cosine table
// lookup, one reach-by-cosine multiply and a compare, so a new item can enter
// every cycle. A beam with s_tlast set ends the scan, and its result is
// loaded from the input register into the output register, which drives
// m_tvalid; other items produce none. The only stall comes from the output
// register: a scan-ending beam waits in the input register while an earlier
// result has not been taken.
// There is no clearing pass after reset. Configuration writes are accepted
// at any time and should be issued only while no item is in flight.
module ttc_emergency_brake (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: speed_mm_s [15:0], range_mm [31:16], range_valid [32]
    input  logic [39:0]                     s_tdata,
    // s_tuser: kind [1:0]
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tlast,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata: brake_on [0], danger_found [1], clear_progress [9:2]
    output logic [15:0]                     m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ttce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttce_pkg::CFG_DATA_W-1:0] cfg_data
);

    ttce_pkg::cfg_t        cfg;
    ttce_pkg::brake_evt_t  evt;
    ttce_pkg::brake_stat_t stat;

    logic                           cfg_wr;

    // Input stage.
    logic                           st_valid_reg;
    logic [1:0]                     st_kind_reg;
    logic [ttce_pkg::SPEED_W-1:0]   st_speed_reg;
    logic [ttce_pkg::RANGE_W-1:0]   st_range_reg;
    logic                           st_rvalid_reg;
    logic                           st_last_reg;

    logic                           is_beam;
    logic                           gives_result;
    logic                           out_free;
    logic                           advance;
    logic                           danger_hit;
    logic                           danger_now;

    // Scan state.
    logic [ttce_pkg::SPEED_W-1:0]   speed_reg;
    logic [ttce_pkg::SPEED_W-1:0]   speed_next;
    logic [ttce_pkg::REACH_W-1:0]   reach_reg;
    logic [ttce_pkg::REACH_W-1:0]   reach_next;
    logic [ttce_pkg::ANGLE_W-1:0]   angle_reg;
    logic [ttce_pkg::ANGLE_W-1:0]   angle_next;
    logic                           seen_reg;
    logic                           seen_next;

    // Output register.
    logic                           out_valid_reg;
    logic                           out_brake_reg;
    logic                           out_danger_reg;
    logic [ttce_pkg::CNT_W-1:0]     out_cnt_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    ttce_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign is_beam      = (st_kind_reg == ttce_pkg::KIND_BEAM);
    assign gives_result = is_beam && st_last_reg;
    assign out_free     = !out_valid_reg || m_tready;
    assign advance      = st_valid_reg && (!gives_result || out_free);
    assign s_tready     = !st_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            st_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            st_kind_reg   <= s_tuser;
            st_speed_reg  <= s_tdata[15:0];
            st_range_reg  <= s_tdata[31:16];
            st_rvalid_reg <= s_tdata[32];
            st_last_reg   <= s_tlast;
        end
    end

    ttce_beam_eval u_beam (
        .beam_angle  (angle_reg),
        .range_mm    (st_range_reg),
        .range_valid (st_rvalid_reg),
        .reach_um    (reach_reg),
        .danger_hit  (danger_hit)
    );

    assign danger_now = seen_reg || danger_hit;

    always_comb
    begin
        speed_next = speed_reg;
        reach_next = reach_reg;
        angle_next = angle_reg;
        seen_next  = seen_reg;
        if (advance && (st_kind_reg == ttce_pkg::KIND_SPEED))
        begin
            speed_next = st_speed_reg;
            if (!st_speed_reg[ttce_pkg::SPEED_W-1] && (st_speed_reg != '0))
            begin
                reach_next = ttce_pkg::REACH_W'(cfg.ttc_threshold_ms)
                             * ttce_pkg::REACH_W'(st_speed_reg[ttce_pkg::SPEED_W-2:0]);
            end
            else
            begin
                reach_next = '0;
            end
        end
        if (advance && is_beam)
        begin
            if (st_last_reg)
            begin
                seen_next  = 1'b0;
                angle_next = cfg.angle_start;
            end
            else
            begin
                seen_next  = danger_now;
                angle_next = angle_reg + cfg.angle_step;
            end
        end
        // Writing the start angle restarts the angle sequence.
        if (cfg_wr && (cfg_index == ttce_pkg::CFG_ANGLE_START))
        begin
            angle_next = cfg_data[ttce_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= '0;
            reach_reg <= '0;
            angle_reg <= ttce_pkg::RST_ANGLE_START;
            seen_reg  <= 1'b0;
        end
        else
        begin
            speed_reg <= speed_next;
            reach_reg <= reach_next;
            angle_reg <= angle_next;
            seen_reg  <= seen_next;
        end
    end

    assign evt.scan_end = advance && gives_result;
    assign evt.tick     = advance && (st_kind_reg == ttce_pkg::KIND_TICK);
    assign evt.danger   = danger_now;
    assign evt.speed_ok = $signed(speed_reg)
                          > $signed({1'b0, cfg.min_speed_mm_s});

    ttce_brake_ctrl u_brake (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .evt   (evt),
        .stat  (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (evt.scan_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.scan_end)
        begin
            out_brake_reg  <= stat.brake_next;
            out_danger_reg <= danger_now;
            out_cnt_reg    <= stat.clear_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_cnt_reg, out_danger_reg, out_brake_reg};

    // The clear count only runs while the brake is latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        !stat.latched |-> (stat.clear_next == '0 || stat.brake_next))
        else $error("clear count nonzero while brake released");

    // A brake can only latch on a scan that reports danger.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stat.latched) |-> (out_valid_reg && out_danger_reg && out_brake_reg))
        else $error("brake latched without a danger result");

    // A scan-ending beam must not be overwritten while its result is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg && gives_result && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input stage accepted over a blocked scan end");

endmodule

// ===== src/ttce_cfg_regs.sv =====
// ============================================================================
// ttce_cfg_regs
// Configuration register file written through the configuration channel.
// ============================================================================
module ttce_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [ttce_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [ttce_pkg::CFG_DATA_W-1:0] wr_data,
    output ttce_pkg::cfg_t                  cfg
);

    ttce_pkg::cfg_t cfg_reg;
    ttce_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                ttce_pkg::CFG_TTC_THRESHOLD:
                    cfg_next.ttc_threshold_ms = wr_data[ttce_pkg::THR_W-1:0];
                ttce_pkg::CFG_MIN_SPEED:
                    cfg_next.min_speed_mm_s = wr_data[ttce_pkg::MINSPD_W-1:0];
                ttce_pkg::CFG_ANGLE_START:
                    cfg_next.angle_start = wr_data[ttce_pkg::ANGLE_W-1:0];
                ttce_pkg::CFG_ANGLE_STEP:
                    cfg_next.angle_step = wr_data[ttce_pkg::ANGLE_W-1:0];
                ttce_pkg::CFG_MIN_HOLD:
                    cfg_next.min_hold_ms = wr_data[ttce_pkg::HOLD_W-1:0];
                ttce_pkg::CFG_CLEAR_SCANS:
                    cfg_next.clear_scans = wr_data[ttce_pkg::CNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ttc_threshold_ms <= ttce_pkg::RST_TTC_THRESHOLD;
            cfg_reg.min_speed_mm_s   <= ttce_pkg::RST_MIN_SPEED;
            cfg_reg.angle_start      <= ttce_pkg::RST_ANGLE_START;
            cfg_reg.angle_step       <= ttce_pkg::RST_ANGLE_STEP;
            cfg_reg.min_hold_ms      <= ttce_pkg::RST_MIN_HOLD;
            cfg_reg.clear_scans      <= ttce_pkg::RST_CLEAR_SCANS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/ttce_beam_eval.sv =====
// ============================================================================
// ttce_beam_eval
// Per-beam danger test: cosine lookup, reach projection and range compare.
// ============================================================================
module ttce_beam_eval (
    input  logic [ttce_pkg::ANGLE_W-1:0] beam_angle,
    input  logic [ttce_pkg::RANGE_W-1:0] range_mm,
    input  logic                         range_valid,
    input  logic [ttce_pkg::REACH_W-1:0] reach_um,
    output logic                         danger_hit
);

    localparam int RANGE_W_X = ttce_pkg::RANGE_W + 10;
    localparam int RHS_W     = ttce_pkg::REACH_W + ttce_pkg::COS_W;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    logic [ttce_pkg::COS_IDX_W-1:0] tab_idx;
    logic [1:0]                     quad;
    logic [ttce_pkg::QTR_IDX_W-1:0] quad_pos;
    logic [ttce_pkg::COS_W-1:0]     cos_val;
    logic [RANGE_W_X-1:0]           range_scaled;
    logic [RHS_W-1:0]               lhs;
    logic [RHS_W-1:0]               rhs;

    // The table index is the top bits of the angle; only the first and
    // fourth quadrants can give a positive cosine.
    assign tab_idx  = beam_angle[ttce_pkg::ANGLE_W-1 -: ttce_pkg::COS_IDX_W];
    assign quad     = tab_idx[ttce_pkg::COS_IDX_W-1 -: 2];
    assign quad_pos = tab_idx[ttce_pkg::QTR_IDX_W-1:0];

    always_comb
    begin
        case (quad)
            QUAD_FIRST:  cos_val = ttce_pkg::COS_Q_FIRST[quad_pos];
            QUAD_FOURTH: cos_val = ttce_pkg::COS_Q_FOURTH[quad_pos];
            default:     cos_val = '0;
        endcase
    end

    assign range_scaled = RANGE_W_X'(range_mm) * RANGE_W_X'(1000);
    assign lhs = RHS_W'({range_scaled, {ttce_pkg::COS_FRAC_BITS{1'b0}}});
    assign rhs = RHS_W'(reach_um) * RHS_W'(cos_val);

    assign danger_hit = range_valid && (range_mm != '0) && (cos_val != '0)
                        && (reach_um != '0) && (lhs < rhs);

endmodule

// ===== src/ttce_brake_ctrl.sv =====
// ============================================================================
// ttce_brake_ctrl
// Brake latch with minimum hold timer and consecutive clear scan counter.
// ============================================================================
module ttce_brake_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ttce_pkg::cfg_t        cfg,
    input  ttce_pkg::brake_evt_t  evt,
    output ttce_pkg::brake_stat_t stat
);

    logic                          latched_reg;
    logic                          latched_next;
    logic [ttce_pkg::CNT_W-1:0]    clear_cnt_reg;
    logic [ttce_pkg::CNT_W-1:0]    clear_cnt_next;
    logic [ttce_pkg::HOLD_W-1:0]   hold_reg;
    logic [ttce_pkg::HOLD_W-1:0]   hold_next;
    logic [ttce_pkg::CNT_W-1:0]    cnt_inc;

    assign cnt_inc = (&clear_cnt_reg) ? clear_cnt_reg : clear_cnt_reg + 1'b1;

    always_comb
    begin
        latched_next   = latched_reg;
        clear_cnt_next = clear_cnt_reg;
        hold_next      = hold_reg;
        if (evt.scan_end)
        begin
            if (evt.danger && evt.speed_ok)
            begin
                if (!latched_reg)
                begin
                    hold_next = '0;
                end
                latched_next   = 1'b1;
                clear_cnt_next = '0;
            end
            else if (latched_reg && (hold_reg >= cfg.min_hold_ms))
            begin
                if (cnt_inc >= cfg.clear_scans)
                begin
                    latched_next   = 1'b0;
                    clear_cnt_next = '0;
                end
                else
                begin
                    clear_cnt_next = cnt_inc;
                end
            end
        end
        else if (evt.tick && latched_reg && !(&hold_reg))
        begin
            hold_next = hold_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg   <= 1'b0;
            clear_cnt_reg <= '0;
            hold_reg      <= '0;
        end
        else
        begin
            latched_reg   <= latched_next;
            clear_cnt_reg <= clear_cnt_next;
            hold_reg      <= hold_next;
        end
    end

    assign stat.latched    = latched_reg;
    assign stat.brake_next = latched_next;
    assign stat.clear_next = clear_cnt_next;

endmodule
